// ----- hdl/bpcc_pkg.sv -----
// Package for the BDP probe congestion controller.
// Holds mode, opcode and register index codes, sequencer states and datapath widths.
// No dependencies.
package bpcc_pkg;

  localparam int DIV_W = 68;
  localparam int DIV_CNT_W = 7;

  localparam logic [2:0] MODE_RECOVER = 3'd0;
  localparam logic [2:0] MODE_STABLE  = 3'd1;
  localparam logic [2:0] MODE_DRAIN   = 3'd2;
  localparam logic [2:0] MODE_GAIN1   = 3'd3;
  localparam logic [2:0] MODE_GAIN2   = 3'd4;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_UNDO    = 2'd2;
  localparam logic [1:0] OP_INIT    = 2'd3;

  localparam logic [1:0] REG_STABLE_PERIODS = 2'd0;
  localparam logic [1:0] REG_MIN_INC        = 2'd1;
  localparam logic [1:0] REG_MAX_INC        = 2'd2;
  localparam logic [1:0] REG_SS_FACTOR      = 2'd3;

  localparam logic [31:0] FLOOR_WIN = 32'd4;
  localparam logic [31:0] US_PER_S  = 32'd1000000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EST_MUL,
    ST_EST_DSTART,
    ST_EST_DWAIT,
    ST_EST_UPD,
    ST_EXP_MUL,
    ST_DECIDE,
    ST_GW_MUL,
    ST_GW_DSTART,
    ST_GW_DWAIT,
    ST_CLAMP,
    ST_PACE,
    ST_PACE_MUL2,
    ST_PACE_MUL3,
    ST_PACE_DSTART,
    ST_PACE_DWAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

endpackage

// ----- hdl/bpcc_if.sv -----
// Valid/ready channel interfaces for events and results.
// Depends on nothing.
interface bpcc_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] now_us;
  logic [31:0] sample_rtt_us;
  logic [31:0] inflight_before;
  logic [15:0] segment_size;

  modport source (output valid, opcode, now_us, sample_rtt_us, inflight_before, segment_size,
                  input ready);
  modport sink (input valid, opcode, now_us, sample_rtt_us, inflight_before, segment_size,
                output ready);
endinterface

interface bpcc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] window;
  logic [31:0] slow_start_threshold;
  logic [63:0] pacing_rate;
  logic [2:0]  current_mode;

  modport source (output valid, window, slow_start_threshold, pacing_rate, current_mode,
                  input ready);
  modport sink (input valid, window, slow_start_threshold, pacing_rate, current_mode,
                output ready);
endinterface

// ----- hdl/bpcc_mul.sv -----
// Shared 32x32 multiplier with a registered 64-bit product.
// No package dependencies.
module bpcc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ----- hdl/bpcc_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on bpcc_pkg for widths and the request struct.
module bpcc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  bpcc_pkg::div_req_t        req,
  output logic                      done,
  output logic [bpcc_pkg::DIV_W-1:0] quotient
);

  logic [31:0]                      rem;
  logic [31:0]                      dsr;
  logic [bpcc_pkg::DIV_CNT_W-1:0]   cnt;
  logic                             busy;
  logic [32:0]                      trial;
  logic [32:0]                      diff;
  logic                             fits;

  assign trial = {rem, quotient[bpcc_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem      <= '0;
        quotient <= req.dividend;
        dsr      <= req.divisor;
        cnt      <= bpcc_pkg::DIV_CNT_W'(bpcc_pkg::DIV_W);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? diff[31:0] : trial[31:0];
        quotient <= {quotient[bpcc_pkg::DIV_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == bpcc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/bdp_probe_congestion_controller_core.sv -----
// BDP probe congestion controller: one event in, one result out, worked off by a
// sequencer over one shared multiplier and one 68-step restoring divider.
// A result is ready once the sequencer reaches its done step: init goes straight there,
// restart and undo pass the pacing step, and a rate sample runs at most two divisions.
// An event is taken only while the sequencer is idle; a result still held at the output stalls the next.
// Reset (synchronous, active high) loads the documented state and register defaults.
module bdp_probe_congestion_controller_core #(
  parameter logic [31:0] MAX_WINDOW         = 32'd32767,
  parameter logic [31:0] INFINITE_THRESHOLD = 32'd2147483647
) (
  input  logic        clk,
  input  logic        rst,
  bpcc_evt_if.sink    evt,
  bpcc_res_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bpcc_pkg::seq_state_t state, state_next;

  logic [31:0] stable_periods;
  logic [15:0] min_inc, max_inc, ss_factor;

  logic [2:0]  mode;
  logic [63:0] mode_since;
  logic [15:0] gain_div;
  logic [31:0] bdp, prior_bdp, recent_rtt, lowest_rtt, cwnd, ssthresh;

  logic [1:0]  op_r;
  logic [63:0] now_r;
  logic [31:0] rtt_r, infl_r;
  logic [15:0] mss_r;
  logic [15:0] gw_f;
  logic [15:0] x_hi;
  logic [63:0] lo_part;
  logic [63:0] rate_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  bpcc_pkg::div_req_t div_req;
  logic                       div_done;
  logic [bpcc_pkg::DIV_W-1:0] quo;

  logic        slow, gain_mode, exp_hit, gw_need, take_est;
  logic [31:0] k_sel, est, gw_a, gw_b, rtt_div;
  logic [32:0] bdp_plus;
  logic [15:0] inc_dec, inc_dbl_min;
  logic [16:0] inc_dbl;

  bpcc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  bpcc_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(quo));

  assign evt.ready = (state == bpcc_pkg::ST_IDLE);

  assign slow      = cwnd < ssthresh;
  assign gain_mode = (mode == bpcc_pkg::MODE_GAIN1) || (mode == bpcc_pkg::MODE_GAIN2);
  assign exp_hit   = now_r > (mode_since + prod);
  assign take_est  = (rtt_r != 32'd0) && (mode == bpcc_pkg::MODE_GAIN2);
  assign gw_need   = exp_hit && (slow ? (mode == bpcc_pkg::MODE_GAIN2 && bdp > prior_bdp)
                                      : (mode == bpcc_pkg::MODE_DRAIN));
  assign est       = quo[31:0];
  assign rtt_div   = (recent_rtt == 32'd0) ? 32'd1 : recent_rtt;
  assign bdp_plus  = {1'b0, bdp} + {1'b0, bpcc_pkg::FLOOR_WIN};
  assign gw_a      = (|quo[bpcc_pkg::DIV_W-1:32]) ? '1 : quo[31:0];
  assign gw_b      = bdp_plus[32] ? '1 : bdp_plus[31:0];
  assign inc_dec   = (gain_div == 16'd0) ? 16'd0 : gain_div - 16'd1;
  assign inc_dbl   = {gain_div, 1'b0};
  assign inc_dbl_min = (inc_dbl < {1'b0, max_inc}) ? inc_dbl[15:0] : max_inc;

  // The wait in round trips depends on the branch the decision step will take.
  always_comb begin
    if (slow) begin
      k_sel = 32'd2;
    end else begin
      unique case (mode)
        bpcc_pkg::MODE_RECOVER: k_sel = 32'd1;
        bpcc_pkg::MODE_STABLE:  k_sel = stable_periods;
        bpcc_pkg::MODE_DRAIN:   k_sel = 32'd1;
        default:                k_sel = 32'd2;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpcc_pkg::ST_IDLE:
        if (evt.valid) state_next = bpcc_pkg::ST_DISPATCH;
      bpcc_pkg::ST_DISPATCH: begin
        unique case (op_r)
          bpcc_pkg::OP_SAMPLE:
            state_next = take_est ? bpcc_pkg::ST_EST_MUL : bpcc_pkg::ST_EST_UPD;
          bpcc_pkg::OP_INIT: state_next = bpcc_pkg::ST_DONE;
          default:           state_next = bpcc_pkg::ST_PACE;
        endcase
      end
      bpcc_pkg::ST_EST_MUL:    state_next = bpcc_pkg::ST_EST_DSTART;
      bpcc_pkg::ST_EST_DSTART: state_next = bpcc_pkg::ST_EST_DWAIT;
      bpcc_pkg::ST_EST_DWAIT:  if (div_done) state_next = bpcc_pkg::ST_EST_UPD;
      bpcc_pkg::ST_EST_UPD:    state_next = bpcc_pkg::ST_EXP_MUL;
      bpcc_pkg::ST_EXP_MUL:    state_next = bpcc_pkg::ST_DECIDE;
      bpcc_pkg::ST_DECIDE:
        state_next = gw_need ? bpcc_pkg::ST_GW_MUL : bpcc_pkg::ST_CLAMP;
      bpcc_pkg::ST_GW_MUL:     state_next = bpcc_pkg::ST_GW_DSTART;
      bpcc_pkg::ST_GW_DSTART:  state_next = bpcc_pkg::ST_GW_DWAIT;
      bpcc_pkg::ST_GW_DWAIT:   if (div_done) state_next = bpcc_pkg::ST_CLAMP;
      bpcc_pkg::ST_CLAMP:      state_next = bpcc_pkg::ST_PACE;
      bpcc_pkg::ST_PACE:
        state_next = gain_mode ? bpcc_pkg::ST_DONE : bpcc_pkg::ST_PACE_MUL2;
      bpcc_pkg::ST_PACE_MUL2:   state_next = bpcc_pkg::ST_PACE_MUL3;
      bpcc_pkg::ST_PACE_MUL3:   state_next = bpcc_pkg::ST_PACE_DSTART;
      bpcc_pkg::ST_PACE_DSTART: state_next = bpcc_pkg::ST_PACE_DWAIT;
      bpcc_pkg::ST_PACE_DWAIT:  if (div_done) state_next = bpcc_pkg::ST_DONE;
      bpcc_pkg::ST_DONE:
        if (!res.valid || res.ready) state_next = bpcc_pkg::ST_IDLE;
      default: state_next = bpcc_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req = '0;
    unique case (state)
      bpcc_pkg::ST_EST_MUL: begin
        mul_a = infl_r;
        mul_b = lowest_rtt;
      end
      bpcc_pkg::ST_EST_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {36'd0, prod[31:0]};
        div_req.divisor  = rtt_r;
      end
      bpcc_pkg::ST_EXP_MUL: begin
        mul_a = k_sel;
        mul_b = recent_rtt;
      end
      bpcc_pkg::ST_GW_MUL: begin
        mul_a = {15'd0, 17'(gw_f) + 17'd1};
        mul_b = bdp;
      end
      bpcc_pkg::ST_GW_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {19'd0, prod[48:0]};
        div_req.divisor  = {16'd0, (gw_f == 16'd0) ? 16'd1 : gw_f};
      end
      bpcc_pkg::ST_PACE: begin
        mul_a = cwnd;
        mul_b = {16'd0, mss_r};
      end
      bpcc_pkg::ST_PACE_MUL2: begin
        mul_a = prod[31:0];
        mul_b = bpcc_pkg::US_PER_S;
      end
      bpcc_pkg::ST_PACE_MUL3: begin
        mul_a = {16'd0, x_hi};
        mul_b = bpcc_pkg::US_PER_S;
      end
      bpcc_pkg::ST_PACE_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'd0, lo_part} + {prod[35:0], 32'd0};
        div_req.divisor  = rtt_div;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bpcc_pkg::ST_IDLE;
      stable_periods <= 32'd32;
      min_inc        <= 16'd2;
      max_inc        <= 16'd128;
      ss_factor      <= 16'd2;
      mode           <= bpcc_pkg::MODE_RECOVER;
      mode_since     <= '0;
      gain_div       <= 16'd2;
      bdp            <= bpcc_pkg::FLOOR_WIN;
      prior_bdp      <= '0;
      recent_rtt     <= 32'd1;
      lowest_rtt     <= '1;
      cwnd           <= bpcc_pkg::FLOOR_WIN;
      ssthresh       <= 32'h7fffffff;
      res.valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          bpcc_pkg::REG_STABLE_PERIODS: stable_periods <= cfg_data;
          bpcc_pkg::REG_MIN_INC:        min_inc        <= cfg_data[15:0];
          bpcc_pkg::REG_MAX_INC:        max_inc        <= cfg_data[15:0];
          bpcc_pkg::REG_SS_FACTOR:      ss_factor      <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      // The final step loads the output register itself, so it owns valid then.
      if (res.valid && res.ready && state != bpcc_pkg::ST_DONE) res.valid <= 1'b0;

      unique case (state)
        bpcc_pkg::ST_IDLE: begin
          if (evt.valid) begin
            op_r   <= evt.opcode;
            now_r  <= evt.now_us;
            rtt_r  <= evt.sample_rtt_us;
            infl_r <= evt.inflight_before;
            mss_r  <= evt.segment_size;
          end
        end
        bpcc_pkg::ST_DISPATCH: begin
          unique case (op_r)
            bpcc_pkg::OP_RESTART: begin
              mode       <= bpcc_pkg::MODE_GAIN1;
              mode_since <= now_r;
              bdp        <= bpcc_pkg::FLOOR_WIN;
              prior_bdp  <= '0;
              cwnd       <= bpcc_pkg::FLOOR_WIN;
              lowest_rtt <= '1;
            end
            bpcc_pkg::OP_UNDO: begin
              if ((gain_mode && gain_div < max_inc) || slow) begin
                gain_div   <= inc_dbl_min;
                mode       <= bpcc_pkg::MODE_RECOVER;
                mode_since <= now_r;
                cwnd       <= bdp;
                ssthresh   <= bdp;
              end
            end
            bpcc_pkg::OP_INIT: begin
              mode       <= bpcc_pkg::MODE_RECOVER;
              mode_since <= now_r;
              gain_div   <= min_inc;
              bdp        <= bpcc_pkg::FLOOR_WIN;
              prior_bdp  <= '0;
              recent_rtt <= 32'd1;
              lowest_rtt <= '1;
              cwnd       <= bpcc_pkg::FLOOR_WIN;
              ssthresh   <= INFINITE_THRESHOLD;
              rate_r     <= '0;
            end
            default: begin
            end
          endcase
        end
        bpcc_pkg::ST_EST_UPD: begin
          if (rtt_r != 32'd0) begin
            if (mode == bpcc_pkg::MODE_GAIN2) begin
              if (bdp == 32'd0)   bdp <= est;
              else if (bdp < est) bdp <= bdp + 32'd1;
              else                bdp <= bdp - 32'd1;
            end
            recent_rtt <= rtt_r;
            if (rtt_r < lowest_rtt) lowest_rtt <= rtt_r;
          end
        end
        bpcc_pkg::ST_DECIDE: begin
          if (slow) begin
            if (mode == bpcc_pkg::MODE_GAIN1) begin
              if (exp_hit) begin
                mode       <= bpcc_pkg::MODE_GAIN2;
                mode_since <= now_r;
              end
            end else if (mode == bpcc_pkg::MODE_GAIN2) begin
              if (exp_hit) begin
                mode_since <= now_r;
                if (bdp > prior_bdp) begin
                  mode      <= bpcc_pkg::MODE_GAIN1;
                  prior_bdp <= bdp;
                  gw_f      <= ss_factor;
                end else begin
                  mode     <= bpcc_pkg::MODE_RECOVER;
                  cwnd     <= bdp;
                  ssthresh <= bdp;
                end
              end
            end else begin
              mode       <= bpcc_pkg::MODE_GAIN1;
              mode_since <= now_r;
              bdp        <= bpcc_pkg::FLOOR_WIN;
              prior_bdp  <= '0;
              cwnd       <= bpcc_pkg::FLOOR_WIN;
              lowest_rtt <= '1;
            end
          end else if (exp_hit) begin
            mode_since <= now_r;
            priority if (mode == bpcc_pkg::MODE_RECOVER || mode == bpcc_pkg::MODE_STABLE) begin
              mode     <= bpcc_pkg::MODE_DRAIN;
              cwnd     <= bpcc_pkg::FLOOR_WIN;
              ssthresh <= bpcc_pkg::FLOOR_WIN;
            end else if (mode == bpcc_pkg::MODE_DRAIN) begin
              mode <= bpcc_pkg::MODE_GAIN1;
              gw_f <= gain_div;
            end else if (mode == bpcc_pkg::MODE_GAIN1) begin
              mode <= bpcc_pkg::MODE_GAIN2;
              bdp  <= '0;
            end else begin
              mode       <= bpcc_pkg::MODE_STABLE;
              cwnd       <= bdp;
              ssthresh   <= bdp;
              gain_div   <= (inc_dec < min_inc) ? min_inc : inc_dec;
              lowest_rtt <= recent_rtt;
            end
          end
        end
        bpcc_pkg::ST_GW_DWAIT: begin
          if (div_done) cwnd <= (gw_a > gw_b) ? gw_a : gw_b;
        end
        bpcc_pkg::ST_CLAMP: begin
          if (cwnd < bpcc_pkg::FLOOR_WIN) cwnd <= bpcc_pkg::FLOOR_WIN;
          else if (cwnd > MAX_WINDOW)     cwnd <= MAX_WINDOW;
        end
        bpcc_pkg::ST_PACE: begin
          if (gain_mode) rate_r <= '0;
        end
        bpcc_pkg::ST_PACE_MUL2: x_hi <= prod[47:32];
        bpcc_pkg::ST_PACE_MUL3: lo_part <= prod;
        bpcc_pkg::ST_PACE_DWAIT: begin
          if (div_done) rate_r <= (|quo[bpcc_pkg::DIV_W-1:64]) ? '1 : quo[63:0];
        end
        bpcc_pkg::ST_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid                <= 1'b1;
            res.window               <= cwnd;
            res.slow_start_threshold <= ssthresh;
            res.pacing_rate          <= rate_r;
            res.current_mode         <= mode;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- verif/bdp_probe_congestion_controller_checker.sv -----
// Checker for the BDP probe congestion controller: watches the event, result and
// register write ports, predicts each result and compares it field by field.
// Depends on bpcc_pkg and the channel interfaces in bpcc_if.
module bdp_probe_congestion_controller_checker (
  input  logic        clk,
  input  logic        rst,
  bpcc_evt_if         evt,
  bpcc_res_if         res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);

  localparam logic [31:0] WIN_CAP   = 32'd32767;
  localparam logic [31:0] NO_THRESH = 32'd2147483647;
  localparam logic [63:0] ALL64     = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [31:0] win;
    logic [31:0] thresh;
    logic [63:0] rate;
    logic [2:0]  mode;
  } ctrl_out_t;

  ctrl_out_t out_q[$];

  // Controller settings and state as the block should hold them.
  logic [31:0] periods, inc_lo, inc_hi, ss_div;
  logic [2:0]  mode;
  logic [63:0] t_trans;
  logic [31:0] inc_f, bdp, bdp_prev, rtt_last, rtt_min, cwnd, ssth;

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hffff_ffff) ? 32'hffff_ffff : v[31:0];
  endfunction

  function automatic logic [31:0] grown_win(logic [31:0] f);
    logic [63:0] d, a;
    d = (f != 0) ? {32'b0, f} : 64'd1;
    a = ({32'b0, f} + 64'd1) * {32'b0, bdp} / d;
    if (sat32(a) > sat32({32'b0, bdp} + 64'd4)) return sat32(a);
    return sat32({32'b0, bdp} + 64'd4);
  endfunction

  function automatic logic timed_out(logic [63:0] now, logic [63:0] k);
    return now > t_trans + k * {32'b0, rtt_last};
  endfunction

  function automatic logic [63:0] pace_rate(logic [15:0] mss);
    logic [63:0] x, r, q, rm, part;
    if (mode == bpcc_pkg::MODE_GAIN1 || mode == bpcc_pkg::MODE_GAIN2) return 64'd0;
    x = {32'b0, cwnd} * {48'b0, mss};
    r = (rtt_last != 0) ? {32'b0, rtt_last} : 64'd1;
    q = x / r;
    rm = x % r;
    part = rm * 64'd1000000 / r;
    if (q > (ALL64 - part) / 64'd1000000) return ALL64;
    return q * 64'd1000000 + part;
  endfunction

  task automatic enter(logic [2:0] m, logic [63:0] now);
    mode = m;
    t_trans = now;
  endtask

  task automatic enter_slow_start(logic [63:0] now);
    enter(bpcc_pkg::MODE_GAIN1, now);
    bdp = bpcc_pkg::FLOOR_WIN;
    bdp_prev = 0;
    cwnd = bpcc_pkg::FLOOR_WIN;
    rtt_min = 32'hffff_ffff;
  endtask

  task automatic enter_recovery(logic [63:0] now);
    enter(bpcc_pkg::MODE_RECOVER, now);
    cwnd = bdp;
    ssth = bdp;
  endtask

  task automatic clear_state(logic [63:0] now);
    mode = bpcc_pkg::MODE_RECOVER;
    t_trans = now;
    inc_f = inc_lo;
    bdp = bpcc_pkg::FLOOR_WIN;
    bdp_prev = 0;
    rtt_last = 1;
    rtt_min = 32'hffff_ffff;
    cwnd = bpcc_pkg::FLOOR_WIN;
  endtask

  task automatic take_sample(logic [63:0] now, logic [31:0] rtt, logic [31:0] infl);
    logic [31:0] prod, est;
    if (rtt != 0) begin
      if (mode == bpcc_pkg::MODE_GAIN2) begin
        prod = infl * rtt_min;
        est = prod / rtt;
        if (bdp == 0) bdp = est;
        else if (bdp < est) bdp = bdp + 1;
        else bdp = bdp - 1;
      end
      rtt_last = rtt;
      if (rtt < rtt_min) rtt_min = rtt;
    end
    if (cwnd < ssth) begin
      if (mode == bpcc_pkg::MODE_GAIN1) begin
        if (timed_out(now, 2)) enter(bpcc_pkg::MODE_GAIN2, now);
      end else if (mode == bpcc_pkg::MODE_GAIN2) begin
        if (timed_out(now, 2)) begin
          if (bdp > bdp_prev) begin
            enter(bpcc_pkg::MODE_GAIN1, now);
            cwnd = grown_win(ss_div);
            bdp_prev = bdp;
          end else begin
            enter_recovery(now);
          end
        end
      end else begin
        enter_slow_start(now);
      end
    end else if (mode == bpcc_pkg::MODE_RECOVER || mode == bpcc_pkg::MODE_STABLE) begin
      if (timed_out(now, (mode == bpcc_pkg::MODE_RECOVER) ? 64'd1 : {32'b0, periods})) begin
        enter(bpcc_pkg::MODE_DRAIN, now);
        cwnd = bpcc_pkg::FLOOR_WIN;
        ssth = bpcc_pkg::FLOOR_WIN;
      end
    end else if (mode == bpcc_pkg::MODE_DRAIN) begin
      if (timed_out(now, 1)) begin
        enter(bpcc_pkg::MODE_GAIN1, now);
        cwnd = grown_win(inc_f);
      end
    end else if (mode == bpcc_pkg::MODE_GAIN1) begin
      if (timed_out(now, 2)) begin
        enter(bpcc_pkg::MODE_GAIN2, now);
        bdp = 0;
      end
    end else if (timed_out(now, 2)) begin
      enter(bpcc_pkg::MODE_STABLE, now);
      cwnd = bdp;
      ssth = bdp;
      if (inc_f > 0) inc_f = inc_f - 1;
      if (inc_f < inc_lo) inc_f = inc_lo;
      rtt_min = rtt_last;
    end
    if (cwnd < bpcc_pkg::FLOOR_WIN) cwnd = bpcc_pkg::FLOOR_WIN;
    if (cwnd > WIN_CAP) cwnd = WIN_CAP;
  endtask

  task automatic apply_event(output ctrl_out_t r);
    logic [63:0] rate;
    logic        react;
    logic [31:0] dbl;
    case (evt.opcode)
      bpcc_pkg::OP_SAMPLE: begin
        take_sample(evt.now_us, evt.sample_rtt_us, evt.inflight_before);
        rate = pace_rate(evt.segment_size);
      end
      bpcc_pkg::OP_RESTART: begin
        enter_slow_start(evt.now_us);
        rate = pace_rate(evt.segment_size);
      end
      bpcc_pkg::OP_UNDO: begin
        react = ((mode == bpcc_pkg::MODE_GAIN1 || mode == bpcc_pkg::MODE_GAIN2)
                 && inc_f < inc_hi) || cwnd < ssth;
        if (react) begin
          dbl = inc_f * 2;
          inc_f = (dbl < inc_hi) ? dbl : inc_hi;
          enter_recovery(evt.now_us);
        end
        rate = pace_rate(evt.segment_size);
      end
      default: begin
        clear_state(evt.now_us);
        ssth = NO_THRESH;
        rate = 0;
      end
    endcase
    r.win = cwnd;
    r.thresh = ssth;
    r.rate = rate;
    r.mode = mode;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fails = fails + 1;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ctrl_out_t e;
    ctrl_out_t p;
    if (rst) begin
      periods = 32;
      inc_lo = 2;
      inc_hi = 128;
      ss_div = 2;
      clear_state(0);
      ssth = 32'h7fff_ffff;
      out_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpcc_pkg::REG_STABLE_PERIODS: periods = cfg_data;
          bpcc_pkg::REG_MIN_INC:        inc_lo = {16'b0, cfg_data[15:0]};
          bpcc_pkg::REG_MAX_INC:        inc_hi = {16'b0, cfg_data[15:0]};
          default:                      ss_div = {16'b0, cfg_data[15:0]};
        endcase
      end
      // Compare first so that a transfer out never meets its own prediction.
      if (res.valid && res.ready) begin
        if (out_q.size() == 0) begin
          report("result with nothing expected", 0, 0);
        end else begin
          e = out_q.pop_front();
          if (res.window != e.win) report("window", res.window, e.win);
          if (res.slow_start_threshold != e.thresh)
            report("slow_start_threshold", res.slow_start_threshold, e.thresh);
          if (res.pacing_rate != e.rate) report("pacing_rate", res.pacing_rate, e.rate);
          if (res.current_mode != e.mode) report("current_mode", res.current_mode, e.mode);
        end
      end
      if (evt.valid && evt.ready) begin
        apply_event(p);
        out_q.push_back(p);
      end
    end
    pending <= out_q.size();
  end

endmodule

// ----- verif/bdp_probe_congestion_controller_core_tb.sv -----
// Testbench top for the BDP probe congestion controller: clock, reset, event
// stimulus, result back-pressure, register writes and the verdict.
// Depends on bpcc_pkg, bpcc_if, the core and the checker module.
module bdp_probe_congestion_controller_core_tb;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fails;
  int          pending;
  int          cyc;
  logic        quiet_tx;
  logic [63:0] clock_us;
  logic [31:0] rtt_base;

  bpcc_evt_if evt_ch();
  bpcc_res_if res_ch();

  bdp_probe_congestion_controller_core dut (
    .clk(clk), .rst(rst), .evt(evt_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bdp_probe_congestion_controller_checker chk (
    .clk(clk), .rst(rst), .evt(evt_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off and one stretch with none.
  always @(posedge clk) begin
    if (rst) begin
      cyc <= 0;
      res_ch.ready <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= 4000 && cyc < 6500) res_ch.ready <= 0;
      else if (cyc >= 12000 && cyc < 20000) res_ch.ready <= 1;
      else res_ch.ready <= ($urandom_range(99) >= 22);
    end
  end

  task automatic send(logic [1:0] op, logic [63:0] now, logic [31:0] rtt,
                      logic [31:0] infl, logic [15:0] mss);
    if (!quiet_tx && $urandom_range(99) < 22) begin
      evt_ch.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    evt_ch.valid <= 1;
    evt_ch.opcode <= op;
    evt_ch.now_us <= now;
    evt_ch.sample_rtt_us <= rtt;
    evt_ch.inflight_before <= infl;
    evt_ch.segment_size <= mss;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic settle();
    evt_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] periods, logic [15:0] lo, logic [15:0] hi,
                            logic [15:0] div);
    logic [31:0] vals [4];
    vals = '{periods, {16'b0, lo}, {16'b0, hi}, {16'b0, div}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Mostly ack-clocked samples with plausible timing, plus restarts, undos,
  // inits and fully random events.
  task automatic random_events(int n);
    int pick;
    logic [31:0] rtt;
    clock_us = 64'd1000;
    rtt_base = $urandom_range(20, 5000);
    send(bpcc_pkg::OP_INIT, clock_us, 0, 0, 1460);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      quiet_tx = (i >= 40 && i < 70);
      if (i == n / 2) settle();
      clock_us += 64'($urandom_range(rtt_base / 4, rtt_base * 3));
      if (pick < 80) begin
        rtt = ($urandom_range(99) < 5) ? 0 : rtt_base + $urandom_range(0, rtt_base / 4);
        send(bpcc_pkg::OP_SAMPLE, clock_us, rtt, $urandom_range(0, 60000),
             16'($urandom_range(1, 65535)));
      end else if (pick < 84) begin
        send(bpcc_pkg::OP_RESTART, clock_us, $urandom, $urandom,
             16'($urandom_range(1, 65535)));
      end else if (pick < 89) begin
        send(bpcc_pkg::OP_UNDO, clock_us, $urandom, $urandom,
             16'($urandom_range(1, 65535)));
      end else if (pick < 91) begin
        send(bpcc_pkg::OP_INIT, clock_us, $urandom, $urandom,
             16'($urandom_range(1, 65535)));
      end else begin
        send(2'($urandom_range(3)), {$urandom, $urandom}, $urandom, $urandom,
             16'($urandom));
        send(bpcc_pkg::OP_INIT, clock_us, 0, 0, 1460);
      end
    end
    quiet_tx = 0;
    settle();
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = bpcc_pkg::REG_STABLE_PERIODS;
    cfg_data = 0;
    quiet_tx = 0;
    evt_ch.valid = 0;
    evt_ch.opcode = bpcc_pkg::OP_SAMPLE;
    evt_ch.now_us = 0;
    evt_ch.sample_rtt_us = 0;
    evt_ch.inflight_before = 0;
    evt_ch.segment_size = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: slow start steps, restart, undo, extreme fields and time wrap.
    send(bpcc_pkg::OP_SAMPLE, 0, 0, 0, 1);
    send(bpcc_pkg::OP_INIT, 1000, 0, 0, 1460);
    send(bpcc_pkg::OP_SAMPLE, 1001, 100, 10, 1460);
    send(bpcc_pkg::OP_SAMPLE, 1300, 100, 20, 1460);
    send(bpcc_pkg::OP_SAMPLE, 1600, 100, 50, 1460);
    send(bpcc_pkg::OP_SAMPLE, 1900, 100, 60, 1460);
    send(bpcc_pkg::OP_SAMPLE, 2200, 100, 60, 1460);
    send(bpcc_pkg::OP_RESTART, 2300, 0, 0, 536);
    send(bpcc_pkg::OP_UNDO, 2400, 0, 0, 536);
    send(bpcc_pkg::OP_UNDO, 2500, 0, 0, 16'hffff);
    send(bpcc_pkg::OP_SAMPLE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
         16'hffff);
    send(bpcc_pkg::OP_SAMPLE, 0, 1, 0, 1);
    send(bpcc_pkg::OP_INIT, 64'hffff_ffff_ffff_ff00, 0, 0, 1);
    send(bpcc_pkg::OP_SAMPLE, 64'hffff_ffff_ffff_ff80, 32'h8000_0000, 32'h0001_0000, 1460);
    send(bpcc_pkg::OP_SAMPLE, 64'hffff_ffff_ffff_fff0, 32'h0000_0001, 32'hffff_ffff, 1460);
    send(bpcc_pkg::OP_UNDO, 64'hffff_ffff_ffff_fff8, 0, 0, 16'hffff);
    send(bpcc_pkg::OP_INIT, 0, 0, 0, 1);
    settle();

    random_events(120);
    write_regs(1, 1, 16'hffff, 1);
    random_events(120);
    write_regs(32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff);
    random_events(100);
    write_regs(4, 3, 16, 3);
    random_events(120);
    write_regs(2, 16'hffff, 1, 1);
    random_events(120);

    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bpcc_pkg.sv
hdl/bpcc_if.sv
hdl/bpcc_mul.sv
hdl/bpcc_div.sv
hdl/bdp_probe_congestion_controller_core.sv
verif/bdp_probe_congestion_controller_checker.sv
verif/bdp_probe_congestion_controller_core_tb.sv
